>>> design/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

    localparam int OUT_FRAC_BITS_DEF = 16;
    localparam int SQRT_STEPS        = 32;
    localparam int DIV_STEPS         = 32;
    localparam int SQRT_GUARD        = 15;
    localparam int SQRT_GUARD2       = 30;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_ONE   = 2'd1,
        ST_TWO   = 2'd2,
        ST_DEGEN = 2'd3
    } status_t;

    // one digit-by-digit square root step
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } sqrt_data_t;

    // one restoring division step
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] divisor;
        logic [31:0] low;
        logic [31:0] quot;
        logic        ovf;
    } div_data_t;

endpackage

`default_nettype wire

>>> design/qrs_sqrt_cell.sv
`default_nettype none

module qrs_sqrt_cell (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire qrs_pkg::sqrt_data_t d_in,
    output qrs_pkg::sqrt_data_t     d_out
);

    qrs_pkg::sqrt_data_t data_reg;
    qrs_pkg::sqrt_data_t data_next;
    logic [35:0]         rem_sh;
    logic [35:0]         trial;

    always_comb
    begin
        rem_sh    = {d_in.rem, d_in.rad[63:62]};
        trial     = {2'b00, d_in.root, 2'b01};
        data_next = d_in;
        data_next.rad = {d_in.rad[61:0], 2'b00};
        if (rem_sh >= trial)
        begin
            data_next.rem  = 34'(rem_sh - trial);
            data_next.root = {d_in.root[30:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh[33:0];
            data_next.root = {d_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

`default_nettype wire

>>> design/qrs_div_cell.sv
`default_nettype none

module qrs_div_cell (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire qrs_pkg::div_data_t d_in,
    output qrs_pkg::div_data_t     d_out
);

    qrs_pkg::div_data_t data_reg;
    qrs_pkg::div_data_t data_next;
    logic [32:0]        rem_sh;

    always_comb
    begin
        rem_sh    = {d_in.rem, d_in.low[31]};
        data_next = d_in;
        data_next.low = {d_in.low[30:0], 1'b0};
        if (rem_sh >= {1'b0, d_in.divisor})
        begin
            data_next.rem  = 32'(rem_sh - {1'b0, d_in.divisor});
            data_next.quot = {d_in.quot[30:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh[31:0];
            data_next.quot = {d_in.quot[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

`default_nettype wire

>>> design/quadratic_root_solver.sv
// Real roots of a*x^2 + b*x + c = 0 for signed Q8.8 coefficients, given as signed
// fixed point with OUT_FRAC_BITS fraction bits, truncated toward zero and clamped to
// 32 bits (saturated is set when a reported root was clamped). One item is accepted
// every cycle unless the output stalls. Registered products feed a discriminant stage,
// a chain of 32 square root cells gives one root bit each, a setup stage prepares the
// quotients, and two chains of 32 division cells give one quotient bit each. A stalled
// output freezes the whole pipeline; in_ready is low only while a result waits.

`default_nettype none

module quadratic_root_solver #(
    parameter int OUT_FRAC_BITS = qrs_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] coef_quadratic,
    input  wire logic signed [15:0] coef_linear,
    input  wire logic signed [15:0] coef_constant,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              root_status,
    output logic signed [31:0]      root_plus,
    output logic signed [31:0]      root_minus,
    output logic                    saturated
);

    localparam int NW = 34 + OUT_FRAC_BITS;
    localparam int SN = qrs_pkg::SQRT_STEPS;
    localparam int DN = qrs_pkg::DIV_STEPS;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        qrs_pkg::status_t   status;
        logic               lin;
    } sq_meta_t;

    typedef struct packed {
        qrs_pkg::status_t status;
        logic             neg_p;
        logic             neg_m;
    } dv_meta_t;

    function automatic logic [32:0] clamp_q(input logic [31:0] q, input logic ovf,
                                            input logic neg);
        logic [32:0] r;
        if (neg)
        begin
            if (ovf || (q > qrs_pkg::Q_MIN))
                r = {1'b1, qrs_pkg::Q_MIN};
            else
                r = {1'b0, 32'(-q)};
        end
        else
        begin
            if (ovf || q[31])
                r = {1'b1, qrs_pkg::Q_MAX};
            else
                r = {1'b0, q};
        end
        return r;
    endfunction

    function automatic logic [33:0] mag34(input logic signed [33:0] x);
        return x[33] ? $unsigned(34'(-x)) : $unsigned(x);
    endfunction

    logic adv;

    // discriminant stages
    logic               s1_valid_reg;
    logic signed [15:0] a1_reg, b1_reg, c1_reg;
    logic signed [31:0] bb1_reg, ac1_reg;
    logic               s2_valid_reg;
    sq_meta_t           s2_meta_reg, s2_meta_next;
    logic [63:0]        s2_rad_reg, s2_rad_next;
    logic signed [34:0] d_w;

    // square root chain
    logic                sq_valid_reg [SN];
    sq_meta_t            sq_meta_reg  [SN];
    qrs_pkg::sqrt_data_t sq_in        [SN];
    qrs_pkg::sqrt_data_t sq_out       [SN];

    // quotient setup
    logic                setup_valid_reg;
    dv_meta_t            setup_meta_reg, setup_meta_next;
    qrs_pkg::div_data_t  setup_p_reg, setup_p_next;
    qrs_pkg::div_data_t  setup_m_reg, setup_m_next;
    sq_meta_t            sm;
    logic signed [33:0]  base_p, base_m, nb;
    logic signed [32:0]  den;
    logic [31:0]         m_w;
    logic [NW-1:0]       np_w, nm_w;

    // division chains
    logic               dv_valid_reg [DN];
    dv_meta_t           dv_meta_reg  [DN];
    qrs_pkg::div_data_t dp_in  [DN];
    qrs_pkg::div_data_t dp_out [DN];
    qrs_pkg::div_data_t dm_in  [DN];
    qrs_pkg::div_data_t dm_out [DN];

    // output register
    logic               out_valid_reg;
    logic [1:0]         status_reg, status_next;
    logic [31:0]        plus_reg, plus_next;
    logic [31:0]        minus_reg, minus_next;
    logic               sat_reg, sat_next;
    logic [32:0]        cl_p, cl_m;
    dv_meta_t           om;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 2: discriminant and case
    always_comb
    begin
        d_w = 35'(bb1_reg) - (35'(ac1_reg) <<< 2);
        s2_meta_next.a   = a1_reg;
        s2_meta_next.b   = b1_reg;
        s2_meta_next.c   = c1_reg;
        s2_meta_next.lin = (a1_reg == 16'sd0);
        if (a1_reg == 16'sd0)
            s2_meta_next.status = (b1_reg == 16'sd0) ? qrs_pkg::ST_DEGEN : qrs_pkg::ST_ONE;
        else if (d_w[34])
            s2_meta_next.status = qrs_pkg::ST_NONE;
        else if (d_w == 35'sd0)
            s2_meta_next.status = qrs_pkg::ST_ONE;
        else
            s2_meta_next.status = qrs_pkg::ST_TWO;
        s2_rad_next = (s2_meta_next.status == qrs_pkg::ST_TWO)
                    ? {1'b0, d_w[32:0], 30'b0} : 64'd0;
    end

    generate
        for (genvar i = 0; i < SN; i++)
        begin : g_sqrt
            if (i == 0)
            begin : g_first
                assign sq_in[i] = '{rem: 34'd0, root: 32'd0, rad: s2_rad_reg};
            end
            else
            begin : g_next
                assign sq_in[i] = sq_out[i-1];
            end
            qrs_sqrt_cell u_cell (
                .clk   (clk),
                .en    (adv),
                .d_in  (sq_in[i]),
                .d_out (sq_out[i])
            );
        end
    endgenerate

    // quotient setup: signed numerator base and denominator per case
    always_comb
    begin
        sm     = sq_meta_reg[SN-1];
        nb     = -(34'(sm.b) <<< qrs_pkg::SQRT_GUARD);
        base_p = 34'sd0;
        base_m = 34'sd0;
        den    = 33'sd1;
        case (sm.status)
            qrs_pkg::ST_ONE:
            begin
                if (sm.lin)
                begin
                    base_p = -34'(sm.c);
                    den    = 33'(sm.b);
                end
                else
                begin
                    base_p = -34'(sm.b);
                    den    = 33'(sm.a) <<< 1;
                end
            end
            qrs_pkg::ST_TWO:
            begin
                base_p = nb + $signed({2'b00, sq_out[SN-1].root});
                base_m = nb - $signed({2'b00, sq_out[SN-1].root});
                den    = 33'(sm.a) <<< (qrs_pkg::SQRT_GUARD + 1);
            end
            default:
            begin
                base_p = 34'sd0;
                den    = 33'sd1;
            end
        endcase
        m_w  = den[32] ? 32'(-den) : den[31:0];
        np_w = NW'(mag34(base_p)) << OUT_FRAC_BITS;
        nm_w = NW'(mag34(base_m)) << OUT_FRAC_BITS;

        setup_p_next.rem     = 32'(np_w[NW-1:32]);
        setup_p_next.divisor = m_w;
        setup_p_next.low     = np_w[31:0];
        setup_p_next.quot    = 32'd0;
        setup_p_next.ovf     = (32'(np_w[NW-1:32]) >= m_w);
        setup_m_next.rem     = 32'(nm_w[NW-1:32]);
        setup_m_next.divisor = m_w;
        setup_m_next.low     = nm_w[31:0];
        setup_m_next.quot    = 32'd0;
        setup_m_next.ovf     = (32'(nm_w[NW-1:32]) >= m_w);

        setup_meta_next.status = sm.status;
        setup_meta_next.neg_p  = base_p[33] ^ den[32];
        setup_meta_next.neg_m  = base_m[33] ^ den[32];
    end

    generate
        for (genvar i = 0; i < DN; i++)
        begin : g_div
            if (i == 0)
            begin : g_first
                assign dp_in[i] = setup_p_reg;
                assign dm_in[i] = setup_m_reg;
            end
            else
            begin : g_next
                assign dp_in[i] = dp_out[i-1];
                assign dm_in[i] = dm_out[i-1];
            end
            qrs_div_cell u_plus (
                .clk   (clk),
                .en    (adv),
                .d_in  (dp_in[i]),
                .d_out (dp_out[i])
            );
            qrs_div_cell u_minus (
                .clk   (clk),
                .en    (adv),
                .d_in  (dm_in[i]),
                .d_out (dm_out[i])
            );
        end
    endgenerate

    // clamp and select by status
    always_comb
    begin
        om   = dv_meta_reg[DN-1];
        cl_p = clamp_q(dp_out[DN-1].quot, dp_out[DN-1].ovf, om.neg_p);
        cl_m = clamp_q(dm_out[DN-1].quot, dm_out[DN-1].ovf, om.neg_m);
        status_next = om.status;
        plus_next   = 32'd0;
        minus_next  = 32'd0;
        sat_next    = 1'b0;
        case (om.status)
            qrs_pkg::ST_ONE:
            begin
                plus_next = cl_p[31:0];
                sat_next  = cl_p[32];
            end
            qrs_pkg::ST_TWO:
            begin
                plus_next  = cl_p[31:0];
                minus_next = cl_m[31:0];
                sat_next   = cl_p[32] | cl_m[32];
            end
            default:
            begin
                sat_next = 1'b0;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            setup_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < SN; i++)
            begin
                sq_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < DN; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg    <= in_valid;
            s2_valid_reg    <= s1_valid_reg;
            sq_valid_reg[0] <= s2_valid_reg;
            for (int i = 1; i < SN; i++)
            begin
                sq_valid_reg[i] <= sq_valid_reg[i-1];
            end
            setup_valid_reg <= sq_valid_reg[SN-1];
            dv_valid_reg[0] <= setup_valid_reg;
            for (int i = 1; i < DN; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
            out_valid_reg <= dv_valid_reg[DN-1];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg      <= coef_quadratic;
            b1_reg      <= coef_linear;
            c1_reg      <= coef_constant;
            bb1_reg     <= coef_linear * coef_linear;
            ac1_reg     <= coef_quadratic * coef_constant;
            s2_meta_reg <= s2_meta_next;
            s2_rad_reg  <= s2_rad_next;
            sq_meta_reg[0] <= s2_meta_reg;
            for (int i = 1; i < SN; i++)
            begin
                sq_meta_reg[i] <= sq_meta_reg[i-1];
            end
            setup_meta_reg <= setup_meta_next;
            setup_p_reg    <= setup_p_next;
            setup_m_reg    <= setup_m_next;
            dv_meta_reg[0] <= setup_meta_reg;
            for (int i = 1; i < DN; i++)
            begin
                dv_meta_reg[i] <= dv_meta_reg[i-1];
            end
            status_reg <= status_next;
            plus_reg   <= plus_next;
            minus_reg  <= minus_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign root_status = status_reg;
    assign root_plus   = $signed(plus_reg);
    assign root_minus  = $signed(minus_reg);
    assign saturated   = sat_reg;

endmodule

`default_nettype wire
